FILE: rtl/core/pwv_pkg.sv
// shared types, constants and arithmetic helpers for the velocity evaluator
`default_nettype none

package pwv_pkg;

    // field widths
    localparam int OP_W     = 2;
    localparam int SEG_IW   = 4;
    localparam int JNT_IW   = 3;
    localparam int POW_W    = 3;
    localparam int COEF_W   = 32;
    localparam int TIME_W   = 24;
    localparam int CFG_W    = 5;
    localparam int OUT_JOINTS = 6;

    // fixed point datapath widths
    localparam int FRAC_T   = 16;
    localparam int PROD_W   = COEF_W + TIME_W + 1;
    localparam int RND_W    = PROD_W - FRAC_T;
    localparam int SMUL_W   = COEF_W + 4;
    localparam int SAT_W    = RND_W + 1;

    localparam logic [CFG_W-1:0]         SEG_USE_RESET = CFG_W'(9);
    localparam logic signed [PROD_W-1:0] ROUND_HALF    = PROD_W'(32768);

    // item operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_COEFF = 2'd0,
        OP_LOAD_DUR   = 2'd1,
        OP_EVAL       = 2'd2
    } op_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_RD_TOP,
        S_INIT,
        S_MUL,
        S_RND,
        S_ADD,
        S_STORE,
        S_FINISH
    } ctl_state_t;

    // operations of the shared arithmetic unit
    typedef enum logic [2:0] {
        H_IDLE,
        H_INIT,
        H_MUL,
        H_RND,
        H_ADD
    } hop_t;

    typedef struct packed {
        hop_t             op;
        logic             rd_en;
        logic [POW_W-1:0] power;
    } hcmd_t;

    typedef struct packed {
        logic done;
        logic past_end;
    } srch_status_t;

    // clamp to the signed 32 bit range
    function automatic logic signed [COEF_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [COEF_W-1:0] r;
        if (!v[SAT_W-1] && (|v[SAT_W-2:COEF_W-1])) begin
            r = {1'b0, {(COEF_W-1){1'b1}}};
        end
        else if (v[SAT_W-1] && !(&v[SAT_W-2:COEF_W-1])) begin
            r = {1'b1, {(COEF_W-1){1'b0}}};
        end
        else begin
            r = v[COEF_W-1:0];
        end
        return r;
    endfunction

    // coefficient times its small power index, by shift and add
    function automatic logic signed [SMUL_W-1:0] mul_small(input logic [COEF_W-1:0] c,
                                                           input logic [POW_W-1:0]  p);
        logic signed [SMUL_W-1:0] e;
        logic signed [SMUL_W-1:0] r;
        e = SMUL_W'($signed(c));
        r = '0;
        if (p[0]) begin
            r = r + e;
        end
        if (p[1]) begin
            r = r + (e <<< 1);
        end
        if (p[2]) begin
            r = r + (e <<< 2);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pwv_seg_search.sv
// duration store and segment search: one segment compared per cycle
`default_nettype none

module pwv_seg_search #(
    parameter  int MAX_SEGMENTS = 16,
    localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [pwv_pkg::TIME_W-1:0] query_time,
    input  wire logic                       dur_we,
    input  wire logic [SEG_AW-1:0]          dur_waddr,
    input  wire logic [pwv_pkg::TIME_W-1:0] dur_wdata,
    input  wire logic [pwv_pkg::CFG_W-1:0]  seg_limit,
    output pwv_pkg::srch_status_t           status,
    output logic      [SEG_AW-1:0]          found_seg,
    output logic      [pwv_pkg::TIME_W-1:0] local_time
);
    import pwv_pkg::*;

    localparam int SEG_CW = $clog2(MAX_SEGMENTS + 1);
    localparam int SUM_W  = TIME_W + SEG_CW;

    logic [TIME_W-1:0] dur_mem [MAX_SEGMENTS];
    logic [TIME_W-1:0] dur_rdata_reg;

    logic              run_reg;
    logic              done_reg;
    logic [SEG_CW-1:0] idx_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [TIME_W-1:0] time_reg;
    logic              past_reg;
    logic [SEG_AW-1:0] found_reg;
    logic [TIME_W-1:0] tl_reg;

    logic [SEG_CW-1:0] idx_inc;
    logic [SEG_AW-1:0] dur_raddr;
    logic [SUM_W-1:0]  seg_end;
    logic [SUM_W-1:0]  time_ext;
    logic [SUM_W-1:0]  tl_full;
    logic              limit_hit;
    logic              time_hit;
    logic              finish;

    // read runs one segment ahead of the compare
    assign idx_inc   = idx_reg + SEG_CW'(1);
    assign dur_raddr = run_reg ? idx_inc[SEG_AW-1:0] : '0;

    // end of current segment and the compare against it
    assign time_ext  = SUM_W'(time_reg);
    assign seg_end   = sum_reg + SUM_W'(dur_rdata_reg);
    assign tl_full   = time_ext - sum_reg;
    assign limit_hit = (32'(idx_reg) >= 32'(seg_limit)) || (32'(idx_reg) >= MAX_SEGMENTS);
    assign time_hit  = time_ext < seg_end;
    assign finish    = run_reg && (limit_hit || time_hit);

    // duration memory
    always_ff @(posedge clk)
    begin
        if (dur_we)
        begin
            dur_mem[dur_waddr] <= dur_wdata;
        end
        dur_rdata_reg <= dur_mem[dur_raddr];
    end

    // search control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= finish;
            if (start)
            begin
                run_reg <= 1'b1;
            end
            else if (finish)
            begin
                run_reg <= 1'b0;
            end
        end
    end

    // running sum, index and result
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            idx_reg  <= '0;
            sum_reg  <= '0;
            time_reg <= query_time;
        end
        else if (run_reg && !finish)
        begin
            idx_reg <= idx_inc;
            sum_reg <= seg_end;
        end
        if (finish)
        begin
            past_reg  <= limit_hit;
            found_reg <= idx_reg[SEG_AW-1:0];
            tl_reg    <= tl_full[TIME_W-1:0];
        end
    end

    assign status.done     = done_reg;
    assign status.past_end = past_reg;
    assign found_seg       = found_reg;
    assign local_time      = tl_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pwv_horner_unit.sv
// coefficient memory and the shared multiply, round and add unit for horner steps
`default_nettype none

module pwv_horner_unit #(
    parameter  int DEPTH  = 576,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic        [ADDR_W-1:0]          waddr,
    input  wire logic        [pwv_pkg::COEF_W-1:0] wdata,
    input  wire logic        [ADDR_W-1:0]          raddr,
    input  wire pwv_pkg::hcmd_t                    cmd,
    input  wire logic        [pwv_pkg::TIME_W-1:0] tl,
    output logic signed      [pwv_pkg::COEF_W-1:0] acc
);
    import pwv_pkg::*;

    logic [COEF_W-1:0] coeff_mem [DEPTH];
    logic [COEF_W-1:0] rdata_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [RND_W-1:0]  t_reg;
    logic signed [SMUL_W-1:0] pc_reg;
    logic signed [COEF_W-1:0] acc_reg;

    logic signed [TIME_W:0]   tl_s;
    logic signed [PROD_W-1:0] mul_out;
    logic signed [PROD_W-1:0] rnd_sum;
    logic signed [SMUL_W-1:0] pc_val;

    // shared multiplier and its neighbours
    assign tl_s    = $signed({1'b0, tl});
    assign mul_out = acc_reg * tl_s;
    assign rnd_sum = prod_reg + ROUND_HALF;
    assign pc_val  = mul_small(rdata_reg, cmd.power);

    // coefficient memory with registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            coeff_mem[waddr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= coeff_mem[raddr];
        end
    end

    // one horner phase per cycle
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            H_IDLE:
            begin
            end
            H_INIT:
            begin
                acc_reg <= sat32(SAT_W'(pc_val));
            end
            H_MUL:
            begin
                prod_reg <= mul_out;
            end
            H_RND:
            begin
                t_reg  <= rnd_sum[PROD_W-1:FRAC_T];
                pc_reg <= pc_val;
            end
            H_ADD:
            begin
                acc_reg <= sat32(SAT_W'(t_reg) + SAT_W'(pc_reg));
            end
            default:
            begin
            end
        endcase
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

FILE: rtl/core/piecewise_poly_velocity_eval_unit.sv
// load items leave the block ready in the next cycle
// evaluate items search the durations for the segment of the query time, then run the horner
// steps for each joint on the shared multiplier, with a multiply, a round and an add phase per step
// one evaluate item at a time; stall is high until its result sits in the output register
// reset clears control state and sets segments_in_use to 9; both stores hold no value until loaded
`default_nettype none

module piecewise_poly_velocity_eval_unit #(
    parameter int MAX_SEGMENTS       = 16,
    parameter int JOINTS             = 6,
    parameter int COEFFS_PER_SEGMENT = 6
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_en,
    input  wire logic        [pwv_pkg::CFG_W-1:0]  cfg_write_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic        [pwv_pkg::OP_W-1:0]   op,
    input  wire logic        [pwv_pkg::SEG_IW-1:0] segment_index,
    input  wire logic        [pwv_pkg::JNT_IW-1:0] joint_index,
    input  wire logic        [pwv_pkg::POW_W-1:0]  power_index,
    input  wire logic signed [pwv_pkg::COEF_W-1:0] coefficient,
    input  wire logic        [pwv_pkg::TIME_W-1:0] duration,
    input  wire logic        [pwv_pkg::TIME_W-1:0] query_time,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed      [pwv_pkg::COEF_W-1:0] vel_joint0,
    output logic signed      [pwv_pkg::COEF_W-1:0] vel_joint1,
    output logic signed      [pwv_pkg::COEF_W-1:0] vel_joint2,
    output logic signed      [pwv_pkg::COEF_W-1:0] vel_joint3,
    output logic signed      [pwv_pkg::COEF_W-1:0] vel_joint4,
    output logic signed      [pwv_pkg::COEF_W-1:0] vel_joint5,
    output logic             [pwv_pkg::SEG_IW-1:0] active_segment,
    output logic                                   past_end
);
    import pwv_pkg::*;

    localparam int SEG_AW      = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int JNT_W       = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int COEFF_DEPTH = MAX_SEGMENTS * JOINTS * COEFFS_PER_SEGMENT;
    localparam int ADDR_W      = (COEFF_DEPTH > 1) ? $clog2(COEFF_DEPTH) : 1;
    localparam logic [POW_W-1:0] PW_TOP  = POW_W'(COEFFS_PER_SEGMENT - 1);
    localparam logic [POW_W-1:0] PW_LAST = POW_W'(1);
    localparam logic [JNT_W-1:0] JN_LAST = JNT_W'(JOINTS - 1);

    ctl_state_t        state_reg, state_next;
    logic [JNT_W-1:0]  jn_reg, jn_next;
    logic [POW_W-1:0]  pw_reg, pw_next;
    logic [CFG_W-1:0]  seg_use_reg;

    logic              out_valid_reg;
    logic signed [COEF_W-1:0] out_vel_reg [OUT_JOINTS];
    logic [SEG_IW-1:0] out_seg_reg;
    logic              out_past_reg;
    logic signed [COEF_W-1:0] vel_stage_reg [JOINTS];

    logic              accept;
    logic              eval_start;
    logic              coeff_we;
    logic              dur_we;
    logic [ADDR_W-1:0] coeff_waddr;
    logic [ADDR_W-1:0] coeff_raddr;
    hcmd_t             hcmd;
    logic              stage_we;
    logic              out_load;
    logic              out_free;

    srch_status_t      srch_st;
    logic [SEG_AW-1:0] found_seg;
    logic [TIME_W-1:0] local_time;
    logic signed [COEF_W-1:0] acc;

    // input handshake and load decode
    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign eval_start = accept && (op == OP_EVAL);
    assign coeff_we   = accept && (op == OP_LOAD_COEFF) && (32'(segment_index) < MAX_SEGMENTS)
                        && (32'(joint_index) < JOINTS) && (32'(power_index) < COEFFS_PER_SEGMENT);
    assign dur_we     = accept && (op == OP_LOAD_DUR) && (32'(segment_index) < MAX_SEGMENTS);

    // coefficient addresses: segment, then joint, then power
    assign coeff_waddr = ADDR_W'((32'(segment_index) * JOINTS + 32'(joint_index))
                                 * COEFFS_PER_SEGMENT + 32'(power_index));
    assign coeff_raddr = ADDR_W'((32'(found_seg) * JOINTS + 32'(jn_reg))
                                 * COEFFS_PER_SEGMENT + 32'(pw_reg));

    assign out_free = !out_valid_reg || !out_stall;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_use_reg <= SEG_USE_RESET;
        end
        else if (cfg_write_en)
        begin
            seg_use_reg <= cfg_write_data;
        end
    end

    pwv_seg_search #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (eval_start),
        .query_time (query_time),
        .dur_we     (dur_we),
        .dur_waddr  (SEG_AW'(segment_index)),
        .dur_wdata  (duration),
        .seg_limit  (seg_use_reg),
        .status     (srch_st),
        .found_seg  (found_seg),
        .local_time (local_time)
    );

    pwv_horner_unit #(
        .DEPTH (COEFF_DEPTH)
    ) u_horner (
        .clk   (clk),
        .we    (coeff_we),
        .waddr (coeff_waddr),
        .wdata (coefficient),
        .raddr (coeff_raddr),
        .cmd   (hcmd),
        .tl    (local_time),
        .acc   (acc)
    );

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            jn_reg    <= '0;
            pw_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            jn_reg    <= jn_next;
            pw_reg    <= pw_next;
        end
    end

    // sequencer next state and unit commands
    always_comb
    begin
        state_next = state_reg;
        jn_next    = jn_reg;
        pw_next    = pw_reg;
        hcmd.op    = H_IDLE;
        hcmd.rd_en = 1'b0;
        hcmd.power = pw_reg;
        stage_we   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (eval_start)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                jn_next = '0;
                pw_next = PW_TOP;
                if (srch_st.done)
                begin
                    state_next = srch_st.past_end ? S_FINISH : S_RD_TOP;
                end
            end
            S_RD_TOP:
            begin
                hcmd.rd_en = 1'b1;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                hcmd.op = H_INIT;
                if (pw_reg == PW_LAST)
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    pw_next    = pw_reg - POW_W'(1);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                hcmd.op    = H_MUL;
                hcmd.rd_en = 1'b1;
                state_next = S_RND;
            end
            S_RND:
            begin
                hcmd.op    = H_RND;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                hcmd.op = H_ADD;
                if (pw_reg == PW_LAST)
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    pw_next    = pw_reg - POW_W'(1);
                    state_next = S_MUL;
                end
            end
            S_STORE:
            begin
                stage_we = 1'b1;
                if (jn_reg == JN_LAST)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    jn_next    = jn_reg + JNT_W'(1);
                    pw_next    = PW_TOP;
                    state_next = S_RD_TOP;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // per joint result staging
    always_ff @(posedge clk)
    begin
        if (stage_we)
        begin
            vel_stage_reg[jn_reg] <= acc;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_past_reg <= srch_st.past_end;
            out_seg_reg  <= srch_st.past_end ? '0 : SEG_IW'(found_seg);
        end
    end

    for (genvar i = 0; i < OUT_JOINTS; i++)
    begin : g_out_vel
        if (i < JOINTS)
        begin : g_used
            always_ff @(posedge clk)
            begin
                if (out_load)
                begin
                    out_vel_reg[i] <= srch_st.past_end ? '0 : vel_stage_reg[i];
                end
            end
        end
        else
        begin : g_unused
            always_ff @(posedge clk)
            begin
                if (out_load)
                begin
                    out_vel_reg[i] <= '0;
                end
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign vel_joint0     = out_vel_reg[0];
    assign vel_joint1     = out_vel_reg[1];
    assign vel_joint2     = out_vel_reg[2];
    assign vel_joint3     = out_vel_reg[3];
    assign vel_joint4     = out_vel_reg[4];
    assign vel_joint5     = out_vel_reg[5];
    assign active_segment = out_seg_reg;
    assign past_end       = out_past_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pwv_checker.sv
// port level checks for the velocity evaluator, bound to the top level
`default_nettype none

module pwv_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic        [pwv_pkg::OP_W-1:0]   op,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic signed [pwv_pkg::COEF_W-1:0] vel_joint0,
    input wire logic signed [pwv_pkg::COEF_W-1:0] vel_joint1,
    input wire logic signed [pwv_pkg::COEF_W-1:0] vel_joint2,
    input wire logic signed [pwv_pkg::COEF_W-1:0] vel_joint3,
    input wire logic signed [pwv_pkg::COEF_W-1:0] vel_joint4,
    input wire logic signed [pwv_pkg::COEF_W-1:0] vel_joint5,
    input wire logic        [pwv_pkg::SEG_IW-1:0] active_segment,
    input wire logic                              past_end
);
    import pwv_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(vel_joint0) && $stable(vel_joint5)
                                   && $stable(active_segment) && $stable(past_end))
        else $error("result item changed while stalled");

    // a time past the end gives zero velocities and segment zero
    a_past_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && past_end |-> vel_joint0 == '0 && vel_joint1 == '0 && vel_joint2 == '0
                                  && vel_joint3 == '0 && vel_joint4 == '0 && vel_joint5 == '0
                                  && active_segment == '0)
        else $error("past end result with non zero fields");

    // an accepted evaluate item keeps the input stalled while it runs
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == OP_EVAL |=> in_stall)
        else $error("input not stalled after evaluate item");

    // load items and unused ops complete at once
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op != OP_EVAL |=> !in_stall)
        else $error("input stalled after load item");

    // a result appears only at the end of a busy stretch
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result item without an evaluate in progress");

endmodule

bind piecewise_poly_velocity_eval_unit pwv_checker u_pwv_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .vel_joint0     (vel_joint0),
    .vel_joint1     (vel_joint1),
    .vel_joint2     (vel_joint2),
    .vel_joint3     (vel_joint3),
    .vel_joint4     (vel_joint4),
    .vel_joint5     (vel_joint5),
    .active_segment (active_segment),
    .past_end       (past_end)
);

`default_nettype wire

FILE: tb/sv/tb_piecewise_poly_velocity_eval_unit.sv
// testbench for the piecewise quintic velocity evaluator with its own prediction of every result
`timescale 1ns / 100ps

module tb_piecewise_poly_velocity_eval_unit;

    import pwv_pkg::*;

    localparam int SEGS   = 16;
    localparam int JOINTS = 6;
    localparam int COEFFS = 6;

    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 150;

    // one input item as driven on the ports
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [SEG_IW-1:0]        seg;
        logic [JNT_IW-1:0]        jnt;
        logic [POW_W-1:0]         pw;
        logic signed [COEF_W-1:0] coef;
        logic [TIME_W-1:0]        dur;
        logic [TIME_W-1:0]        qt;
    } traj_item_t;

    // one expected velocity result
    typedef struct packed {
        logic [OUT_JOINTS-1:0][COEF_W-1:0] vel;
        logic [SEG_IW-1:0]                 active_seg;
        logic                              beyond_end;
    } vel_result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                     cfg_write_en;
    logic [CFG_W-1:0]         cfg_write_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [OP_W-1:0]          op;
    logic [SEG_IW-1:0]        segment_index;
    logic [JNT_IW-1:0]        joint_index;
    logic [POW_W-1:0]         power_index;
    logic signed [COEF_W-1:0] coefficient;
    logic [TIME_W-1:0]        duration;
    logic [TIME_W-1:0]        query_time;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [COEF_W-1:0] vel_joint0;
    logic signed [COEF_W-1:0] vel_joint1;
    logic signed [COEF_W-1:0] vel_joint2;
    logic signed [COEF_W-1:0] vel_joint3;
    logic signed [COEF_W-1:0] vel_joint4;
    logic signed [COEF_W-1:0] vel_joint5;
    logic [SEG_IW-1:0]        active_segment;
    logic                     past_end;

    // predictor copy of the trajectory and the register
    logic signed [COEF_W-1:0] coeff_mem [SEGS][JOINTS][COEFFS];
    logic [TIME_W-1:0]        dur_mem [SEGS];
    logic [CFG_W-1:0]         seg_use_cfg = SEG_USE_RESET;

    vel_result_t vel_expect_q [$];
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          cycle_count    = 0;
    bit          idle_on        = 1'b1;
    int          stall_left     = 0;

    piecewise_poly_velocity_eval_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .segment_index  (segment_index),
        .joint_index    (joint_index),
        .power_index    (power_index),
        .coefficient    (coefficient),
        .duration       (duration),
        .query_time     (query_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .vel_joint0     (vel_joint0),
        .vel_joint1     (vel_joint1),
        .vel_joint2     (vel_joint2),
        .vel_joint3     (vel_joint3),
        .vel_joint4     (vel_joint4),
        .vel_joint5     (vel_joint5),
        .active_segment (active_segment),
        .past_end       (past_end)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run time guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver stalls in random bursts while idling is on
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 9);
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin : result_check
        vel_result_t                       want;
        logic [OUT_JOINTS-1:0][COEF_W-1:0] got_vel;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got_vel = {vel_joint5, vel_joint4, vel_joint3, vel_joint2, vel_joint1, vel_joint0};
            if (vel_expect_q.size() == 0)
            begin
                $error("velocity result with no evaluate item outstanding");
                mismatch_count++;
            end
            else
            begin
                want = vel_expect_q.pop_front();
                for (int j = 0; j < OUT_JOINTS; j++)
                begin
                    if (got_vel[j] !== want.vel[j])
                    begin
                        $error("vel_joint%0d expected %0d got %0d", j,
                               $signed(want.vel[j]), $signed(got_vel[j]));
                        mismatch_count++;
                    end
                end
                if (active_segment !== want.active_seg)
                begin
                    $error("active_segment expected %0d got %0d",
                           want.active_seg, active_segment);
                    mismatch_count++;
                end
                if (past_end !== want.beyond_end)
                begin
                    $error("past_end expected %0d got %0d", want.beyond_end, past_end);
                    mismatch_count++;
                end
            end
        end
    end

    // clamp to the signed 32 bit range
    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // derivative of one joint polynomial by horner's rule, rounding half up
    function automatic logic [COEF_W-1:0] joint_velocity(input int s, input int j,
                                                         input logic [TIME_W-1:0] tl);
        longint acc;
        acc = clamp32(longint'(COEFFS - 1) * longint'(coeff_mem[s][j][COEFFS-1]));
        for (int p = COEFFS - 2; p >= 1; p--)
        begin
            acc = clamp32(((acc * longint'(tl) + 64'sd32768) >>> 16)
                          + longint'(p) * longint'(coeff_mem[s][j][p]));
        end
        return acc[COEF_W-1:0];
    endfunction

    // segments searched, with register values above the store size capped
    function automatic int used_segments();
        return (int'(seg_use_cfg) > SEGS) ? SEGS : int'(seg_use_cfg);
    endfunction

    // start time of a segment, sum of all earlier durations
    function automatic longint segment_start(input int k);
        longint sum;
        sum = 0;
        for (int i = 0; i < k; i++)
            sum += longint'(dur_mem[i]);
        return sum;
    endfunction

    // velocities for one query time; the trajectory is fully loaded before any
    // query with segments in use, so no unwritten entry is ever read
    function automatic vel_result_t velocity_at(input logic [TIME_W-1:0] t);
        vel_result_t r;
        longint      base;
        int          seg;
        bit          hit;
        r    = '0;
        base = 0;
        seg  = 0;
        hit  = 1'b0;
        for (int i = 0; i < used_segments(); i++)
        begin
            if (!hit)
            begin
                if (longint'(t) < base + longint'(dur_mem[i]))
                begin
                    seg = i;
                    hit = 1'b1;
                end
                else
                begin
                    base += longint'(dur_mem[i]);
                end
            end
        end
        if (hit)
        begin
            for (int j = 0; j < JOINTS; j++)
                r.vel[j] = joint_velocity(seg, j, TIME_W'(longint'(t) - base));
            r.active_seg = seg[SEG_IW-1:0];
        end
        else
        begin
            r.beyond_end = 1'b1;
        end
        return r;
    endfunction

    // apply an accepted item to the predictor
    function automatic void track_item(input traj_item_t it);
        case (it.op)
            OP_LOAD_COEFF:
            begin
                if (it.jnt < JOINTS && it.pw < COEFFS)
                    coeff_mem[it.seg][it.jnt][it.pw] = it.coef;
            end
            OP_LOAD_DUR:
            begin
                dur_mem[it.seg] = it.dur;
            end
            OP_EVAL:
            begin
                vel_expect_q.insert(vel_expect_q.size(), velocity_at(it.qt));
            end
            default:
            begin
            end
        endcase
    endfunction

    // random coefficient, mostly within one unit, sometimes anywhere
    function automatic logic signed [COEF_W-1:0] rand_coeff();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return COEF_W'($urandom_range(0, 33554432)) - 32'd16777216;
        if (r < 85)
            return COEF_W'($urandom_range(0, 536870912)) - 32'd268435456;
        return COEF_W'($urandom);
    endfunction

    // random duration, mostly a fraction of a second to two seconds
    function automatic logic [TIME_W-1:0] rand_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return TIME_W'($urandom_range(4096, 131072));
        if (r < 85)
            return '0;
        if (r < 95)
            return TIME_W'($urandom_range(0, 1048576));
        return TIME_W'($urandom);
    endfunction

    // item with every field random and an unused op
    function automatic traj_item_t noise_item();
        traj_item_t it;
        it.op   = OP_RESERVED;
        it.seg  = SEG_IW'($urandom);
        it.jnt  = JNT_IW'($urandom);
        it.pw   = POW_W'($urandom);
        it.coef = COEF_W'($urandom);
        it.dur  = TIME_W'($urandom);
        it.qt   = TIME_W'($urandom);
        return it;
    endfunction

    function automatic traj_item_t coeff_item(input int s, input int j, input int p,
                                              input logic signed [COEF_W-1:0] v);
        traj_item_t it;
        it      = noise_item();
        it.op   = OP_LOAD_COEFF;
        it.seg  = SEG_IW'(s);
        it.jnt  = JNT_IW'(j);
        it.pw   = POW_W'(p);
        it.coef = v;
        return it;
    endfunction

    function automatic traj_item_t duration_item(input int s, input logic [TIME_W-1:0] d);
        traj_item_t it;
        it     = noise_item();
        it.op  = OP_LOAD_DUR;
        it.seg = SEG_IW'(s);
        it.dur = d;
        return it;
    endfunction

    function automatic traj_item_t eval_item(input logic [TIME_W-1:0] t);
        traj_item_t it;
        it    = noise_item();
        it.op = OP_EVAL;
        it.qt = t;
        return it;
    endfunction

    // query time: inside the trajectory, on or just before a boundary, or anywhere
    function automatic logic [TIME_W-1:0] pick_query_time();
        longint span;
        longint bound;
        int     r;
        span = segment_start(used_segments());
        if (span > longint'(24'hFFFFFF))
            span = longint'(24'hFFFFFF);
        r = $urandom_range(0, 99);
        if (r < 60)
            return TIME_W'($urandom_range(0, int'(span + span / 8 + 1)));
        bound = segment_start($urandom_range(0, used_segments()));
        if (r < 75 && bound <= longint'(24'hFFFFFF))
            return TIME_W'(bound);
        if (r < 85 && bound >= 1 && bound <= longint'(24'hFFFFFF) + 1)
            return TIME_W'(bound - 1);
        return TIME_W'($urandom);
    endfunction

    // send one item, hold it until accepted, then maybe leave a gap
    task automatic push_item(input traj_item_t it);
        in_valid      <= 1'b1;
        op            <= it.op;
        segment_index <= it.seg;
        joint_index   <= it.jnt;
        power_index   <= it.pw;
        coefficient   <= it.coef;
        duration      <= it.dur;
        query_time    <= it.qt;
        do
            @(posedge clk);
        while (in_stall);
        track_item(it);
        items_sent++;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // stop sending until every outstanding evaluate has produced its result
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (vel_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // register write with the block idle
    task automatic set_segments_in_use(input logic [CFG_W-1:0] v);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        seg_use_cfg = v;
    endtask

    // rewrite one whole segment, then query somewhere inside it
    task automatic reload_segment(input int s);
        longint start;
        push_item(duration_item(s, rand_duration()));
        for (int j = 0; j < JOINTS; j++)
            for (int p = COEFFS - 1; p >= 0; p--)
                push_item(coeff_item(s, j, p, rand_coeff()));
        start = segment_start(s);
        if (s < used_segments() && dur_mem[s] != 0
            && start + longint'(dur_mem[s]) <= longint'(24'hFFFFFF) + 1)
            push_item(eval_item(TIME_W'(start + $urandom_range(0, int'(dur_mem[s]) - 1))));
    endtask

    // random mix of queries, loads, broken loads and unused ops
    task automatic random_mix(input int count);
        int first;
        int r;
        first = items_sent;
        while (items_sent - first < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                push_item(eval_item(pick_query_time()));
            else if (r < 75)
                push_item(coeff_item($urandom_range(0, SEGS - 1), $urandom_range(0, JOINTS - 1),
                                     $urandom_range(0, COEFFS - 1), rand_coeff()));
            else if (r < 83)
                push_item(duration_item($urandom_range(0, SEGS - 1), rand_duration()));
            else if (r < 86)
                push_item(coeff_item($urandom_range(0, SEGS - 1), $urandom_range(JOINTS, 7),
                                     $urandom_range(0, 7), rand_coeff()));
            else if (r < 89)
                push_item(coeff_item($urandom_range(0, SEGS - 1), $urandom_range(0, 7),
                                     $urandom_range(COEFFS, 7), rand_coeff()));
            else if (r < 93)
                push_item(noise_item());
            else if (r < 96)
                reload_segment($urandom_range(0, SEGS - 1));
            else
                push_item(eval_item(TIME_W'($urandom)));
        end
    endtask

    // no segments in use: every query lies past the end; broken loads are dropped
    task automatic test_empty_trajectory();
        set_segments_in_use(5'd0);
        push_item(eval_item(24'h000000));
        push_item(eval_item(24'hFFFFFF));
        push_item(noise_item());
        push_item(coeff_item(0, 6, 0, 32'h7FFFFFFF));
        push_item(coeff_item(15, 7, 5, 32'h80000000));
        push_item(coeff_item(3, 2, 6, rand_coeff()));
        push_item(coeff_item(8, 5, 7, rand_coeff()));
    endtask

    // load every duration and coefficient with random content
    task automatic test_load_trajectory();
        for (int s = 0; s < SEGS; s++)
        begin
            push_item(duration_item(s, TIME_W'($urandom_range(4096, 131072))));
            for (int j = 0; j < JOINTS; j++)
                for (int p = COEFFS - 1; p >= 0; p--)
                    push_item(coeff_item(s, j, p, rand_coeff()));
        end
    endtask

    // extremes of coefficients and durations, boundaries, register above range
    task automatic test_directed_cases();
        set_segments_in_use(5'd16);
        push_item(duration_item(0, 24'h010000));
        // zero-length segment right after the first one
        push_item(duration_item(1, 24'h000000));
        push_item(duration_item(2, 24'h008000));
        push_item(coeff_item(0, 0, 5, 32'h7FFFFFFF));
        push_item(coeff_item(0, 1, 5, 32'h80000000));
        push_item(coeff_item(0, 2, 1, 32'h7FFFFFFF));
        push_item(coeff_item(0, 3, 1, 32'h80000000));
        push_item(coeff_item(0, 4, 2, 32'hFFFFFFFF));
        push_item(eval_item(24'h000000));
        push_item(eval_item(24'h00FFFF));
        // end of the first segment falls through the empty one
        push_item(eval_item(24'h010000));
        push_item(eval_item(24'h017FFF));
        push_item(eval_item(24'h018000));
        push_item(duration_item(15, 24'hFFFFFF));
        push_item(eval_item(24'hFFFFFF));
        push_item(eval_item(TIME_W'(segment_start(15))));
        set_segments_in_use(5'd31);
        push_item(eval_item(24'hFFFFFF));
        push_item(eval_item(24'h000000));
        set_segments_in_use(5'd1);
        push_item(eval_item(24'h00FFFF));
        push_item(eval_item(24'h010000));
    endtask

    // random traffic over several register settings, one drain pause in each
    task automatic test_random_traffic();
        logic [CFG_W-1:0] settings [4];
        settings = '{5'd1, 5'd16, 5'd31, 5'd6};
        foreach (settings[k])
        begin
            set_segments_in_use(settings[k]);
            random_mix(40);
            wait_results_drained();
            random_mix(40);
        end
    endtask

    // last stretch without idling on either side
    task automatic test_quiet_tail();
        idle_on = 1'b0;
        set_segments_in_use(SEG_USE_RESET);
        random_mix(60);
    endtask

    // sequence of tests
    initial
    begin
        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= '0;
        in_valid       <= 1'b0;
        op             <= OP_LOAD_COEFF;
        segment_index  <= '0;
        joint_index    <= '0;
        power_index    <= '0;
        coefficient    <= '0;
        duration       <= '0;
        query_time     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_trajectory();
        test_load_trajectory();
        test_directed_cases();
        test_random_traffic();
        test_quiet_tail();

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/pwv_pkg.sv
rtl/core/pwv_seg_search.sv
rtl/core/pwv_horner_unit.sv
rtl/core/piecewise_poly_velocity_eval_unit.sv
rtl/core/pwv_checker.sv
tb/sv/tb_piecewise_poly_velocity_eval_unit.sv
